[sv/ttl_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the text token lexer.
// Used by ttl_lex_core, ttl_emitter and text_token_lexer_unit; no dependencies.
package ttl_pkg;

  // Width of the internal byte position counter
  localparam int unsigned OFFSET_WIDTH = 16;
  // Width of offset and length fields on the result port
  localparam int unsigned FIELD_W      = 16;
  // Most tokens a single byte can produce
  localparam int unsigned MAX_TOKS     = 3;

  localparam logic [OFFSET_WIDTH-1:0] POS_LIMIT = {OFFSET_WIDTH{1'b1}};
  // Length of a one-byte token, at the widened position width
  localparam logic [OFFSET_WIDTH:0]   SPAN_ONE  = {{OFFSET_WIDTH{1'b0}}, 1'b1};

  localparam logic [31:0] HASH_MULT = 32'd97;
  localparam logic [31:0] DEC_MULT  = 32'd10;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [3:0] {
    TK_ERROR  = 4'd0,
    TK_LPAREN = 4'd1,
    TK_RPAREN = 4'd2,
    TK_LBRACE = 4'd3,
    TK_RBRACE = 4'd4,
    TK_COMMA  = 4'd5,
    TK_EQUAL  = 4'd6,
    TK_MINUS  = 4'd7,
    TK_SEMI   = 4'd8,
    TK_INT    = 4'd9,
    TK_IDENT  = 4'd10,
    TK_STRING = 4'd11,
    TK_END    = 4'd12
  } tok_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNEXPECT = 2'd1,
    ERR_UNTERM   = 2'd2
  } err_cause_e;

  typedef enum logic [1:0] {
    RUN_NONE   = 2'd0,
    RUN_INT    = 2'd1,
    RUN_IDENT  = 2'd2,
    RUN_STRING = 2'd3
  } run_kind_e;

  typedef struct packed {
    tok_kind_e          kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [31:0]        value;
    logic [31:0]        hash;
    err_cause_e         cause;
    logic               last;
  } tok_t;

  // Tokens produced by one byte, in emission order
  typedef struct packed {
    tok_t [MAX_TOKS-1:0] slot;
    logic [1:0]          cnt;
  } batch_t;

  // Saturate a position-sized value to the result field width
  function automatic logic [FIELD_W-1:0] clamp_field(input logic [OFFSET_WIDTH:0] v);
    logic [33:0] wide;
    wide = {{(33 - OFFSET_WIDTH){1'b0}}, v};
    if (wide > 34'd65535) begin
      return {FIELD_W{1'b1}};
    end
    return FIELD_W'(v);
  endfunction

endpackage

[sv/ttl_lex_core.sv]
`timescale 1ns / 1ps
// Lexer state registers and the per-byte classification and token build logic.
// Depends on ttl_pkg.
module ttl_lex_core import ttl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] data_byte_i,
  input  logic       eob_i,
  output batch_t     batch_o
);

  run_kind_e               run_q, run_d;
  logic [OFFSET_WIDTH-1:0] pos_q, pos_d;
  logic [OFFSET_WIDTH-1:0] start_q, start_d;
  logic [31:0]             value_q, value_d;
  logic [31:0]             hash_q, hash_d;

  function automatic tok_kind_e punct_kind(input logic [7:0] c);
    unique case (c)
      CH_LPAREN: return TK_LPAREN;
      CH_RPAREN: return TK_RPAREN;
      CH_LBRACE: return TK_LBRACE;
      CH_RBRACE: return TK_RBRACE;
      CH_COMMA:  return TK_COMMA;
      CH_EQUAL:  return TK_EQUAL;
      CH_MINUS:  return TK_MINUS;
      CH_SEMI:   return TK_SEMI;
      default:   return TK_ERROR;
    endcase
  endfunction

  function automatic tok_t mk_tok(input tok_kind_e k, input logic [OFFSET_WIDTH:0] s,
                                  input logic [OFFSET_WIDTH:0] l, input logic [31:0] v,
                                  input logic [31:0] h, input err_cause_e e);
    tok_t t;
    t.kind  = k;
    t.start = clamp_field(s);
    t.len   = clamp_field(l);
    t.value = v;
    t.hash  = h;
    t.cause = e;
    t.last  = 1'b0;
    return t;
  endfunction

  // Byte classes
  logic        is_digit, is_letter, is_space, is_quote;
  tok_kind_e   pk;
  logic [31:0] digit_val, byte_val;

  assign is_digit  = (data_byte_i >= CH_ZERO) && (data_byte_i <= CH_NINE);
  assign is_letter = ((data_byte_i >= CH_LO_A) && (data_byte_i <= CH_LO_Z)) ||
                     ((data_byte_i >= CH_UP_A) && (data_byte_i <= CH_UP_Z));
  assign is_space  = (data_byte_i == CH_SPACE) ||
                     ((data_byte_i >= CH_TAB) && (data_byte_i <= CH_CR));
  assign is_quote  = (data_byte_i == CH_QUOTE);
  assign pk        = punct_kind(data_byte_i);
  assign digit_val = {24'd0, data_byte_i - CH_ZERO};
  assign byte_val  = {24'd0, data_byte_i};

  // Build the token list and the next run state for this byte
  always_comb begin
    tok_t                  toks [MAX_TOKS];
    logic [1:0]            n;
    logic                  fresh;
    logic [OFFSET_WIDTH:0] pos_x, start_x, after_x;

    run_d   = run_q;
    pos_d   = pos_q;
    start_d = start_q;
    value_d = value_q;
    hash_d  = hash_q;
    fresh   = 1'b1;
    n       = 2'd0;
    for (int i = 0; i < MAX_TOKS; i++) begin
      toks[i] = '0;
    end
    pos_x   = {1'b0, pos_q};
    start_x = {1'b0, start_q};
    after_x = (pos_q == POS_LIMIT) ? pos_x : pos_x + 1'b1;

    // Continue or close the pending run
    unique case (run_q)
      RUN_STRING: begin
        fresh = 1'b0;
        if (is_quote) begin
          toks[n] = mk_tok(TK_STRING, start_x, pos_x - start_x + 1'b1, '0, '0, ERR_NONE);
          n       = n + 2'd1;
          run_d   = RUN_NONE;
        end
      end
      RUN_INT: begin
        if (is_digit) begin
          value_d = value_q * DEC_MULT + digit_val;
          fresh   = 1'b0;
        end else begin
          toks[n] = mk_tok(TK_INT, start_x, pos_x - start_x, value_q, '0, ERR_NONE);
          n       = n + 2'd1;
          run_d   = RUN_NONE;
        end
      end
      RUN_IDENT: begin
        if (is_letter || is_digit) begin
          hash_d = hash_q * HASH_MULT + byte_val;
          fresh  = 1'b0;
        end else begin
          toks[n] = mk_tok(TK_IDENT, start_x, pos_x - start_x, '0, hash_q, ERR_NONE);
          n       = n + 2'd1;
          run_d   = RUN_NONE;
        end
      end
      RUN_NONE: begin
      end
    endcase

    // Lex the byte as the start of something new
    if (fresh && !is_space) begin
      if (pk != TK_ERROR) begin
        toks[n] = mk_tok(pk, pos_x, SPAN_ONE, '0, '0, ERR_NONE);
        n       = n + 2'd1;
      end else if (is_quote) begin
        run_d   = RUN_STRING;
        start_d = pos_q;
      end else if (is_digit) begin
        run_d   = RUN_INT;
        start_d = pos_q;
        value_d = digit_val;
      end else if (is_letter) begin
        run_d   = RUN_IDENT;
        start_d = pos_q;
        hash_d  = byte_val;
      end else begin
        toks[n] = mk_tok(TK_ERROR, pos_x, SPAN_ONE, '0, '0, ERR_UNEXPECT);
        n       = n + 2'd1;
      end
    end

    // Flush at end of buffer, or advance the position
    if (eob_i) begin
      // A run may have opened on this very byte
      start_x = {1'b0, start_d};
      unique case (run_d)
        RUN_INT: begin
          toks[n] = mk_tok(TK_INT, start_x, after_x - start_x, value_d, '0, ERR_NONE);
          n       = n + 2'd1;
        end
        RUN_IDENT: begin
          toks[n] = mk_tok(TK_IDENT, start_x, after_x - start_x, '0, hash_d, ERR_NONE);
          n       = n + 2'd1;
        end
        RUN_STRING: begin
          toks[n] = mk_tok(TK_ERROR, {1'b0, start_d}, pos_x - {1'b0, start_d} + 1'b1,
                           '0, '0, ERR_UNTERM);
          n       = n + 2'd1;
        end
        RUN_NONE: begin
        end
      endcase
      toks[n] = mk_tok(TK_END, pos_x + 1'b1, '0, '0, '0, ERR_NONE);
      n       = n + 2'd1;
      run_d   = RUN_NONE;
      pos_d   = '0;
      start_d = '0;
      value_d = '0;
      hash_d  = '0;
    end else if (pos_q != POS_LIMIT) begin
      pos_d = pos_q + 1'b1;
    end

    // Mark the final token of the beat
    for (int i = 0; i < MAX_TOKS; i++) begin
      toks[i].last = (2'(i) == n - 2'd1);
      batch_o.slot[i] = toks[i];
    end
    batch_o.cnt = n;
  end

  // Hold run state; update on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= RUN_NONE;
      pos_q   <= '0;
      start_q <= '0;
      value_q <= '0;
      hash_q  <= '0;
    end else if (fire_i) begin
      run_q   <= run_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      value_q <= value_d;
      hash_q  <= hash_d;
    end
  end

  a_eob_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && eob_i |=> run_q == RUN_NONE && pos_q == '0)
    else $error("state not cleared after end of buffer");

  a_eob_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && eob_i |-> batch_o.cnt != 2'd0)
    else $error("end of buffer produced no token");

  a_start_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q != RUN_NONE |-> start_q <= pos_q)
    else $error("run start beyond current position");

endmodule

[sv/ttl_emitter.sv]
`timescale 1ns / 1ps
// Result buffer: holds the tokens of one byte and drains them one beat a cycle while out_stall_i is low.
// Depends on ttl_pkg.
module ttl_emitter import ttl_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  batch_t batch_i,
  output logic   in_stall_o,
  output logic   fire_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output tok_t   tok_o
);

  tok_t       slot_q [MAX_TOKS];
  logic [1:0] cnt_q;
  logic       pop, load_ok;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  // Take a new batch when empty or when the final token leaves this cycle
  assign load_ok     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign in_stall_o  = !load_ok;
  assign fire_o      = in_valid_i && load_ok;
  assign tok_o       = slot_q[0];

  // Count of tokens still held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (fire_o) begin
      cnt_q <= batch_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Load a fresh batch or advance the queue
  always_ff @(posedge clk_i) begin
    if (fire_o) begin
      for (int i = 0; i < MAX_TOKS; i++) begin
        slot_q[i] <= batch_i.slot[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_TOKS - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
  end

  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd1 |-> slot_q[0].last)
    else $error("final held token not marked last");

  a_last_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q > 2'd1 |-> !slot_q[0].last)
    else $error("last marked before the final token");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_o && batch_i.cnt != 2'd0 |=> out_valid_o)
    else $error("loaded tokens not presented");

endmodule

[sv/text_token_lexer_unit.sv]
`timescale 1ns / 1ps
// Text token lexer top level. The first token of a byte appears in the cycle
// after the byte is accepted. Throughput: one byte per cycle while each byte
// yields at most one token and the result side does not stall; a byte that yields
// more than one token holds the input until its last token leaves the result port.
// Reset (async, active low) clears run state, byte position and the buffer.
module text_token_lexer_unit import ttl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic [31:0] literal_value_o,
  output logic [31:0] ident_hash_o,
  output logic [1:0]  error_cause_o,
  output logic        last_result_o
);

  batch_t batch;
  tok_t   tok;
  logic   fire;

  ttl_lex_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .data_byte_i (data_byte_i),
    .eob_i       (end_of_buffer_i),
    .batch_o     (batch)
  );

  ttl_emitter u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .batch_i     (batch),
    .in_stall_o  (in_stall_o),
    .fire_o      (fire),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tok_o       (tok)
  );

  // Unpack the head token onto the result ports
  assign token_kind_o    = tok.kind;
  assign start_offset_o  = tok.start;
  assign token_length_o  = tok.len;
  assign literal_value_o = tok.value;
  assign ident_hash_o    = tok.hash;
  assign error_cause_o   = tok.cause;
  assign last_result_o   = tok.last;

endmodule

[tb/lexer_token_check.sv]
`timescale 1ns / 1ps
// Result checker for text_token_lexer_unit: watches both channels, predicts the
// token beats of every accepted byte and compares them in order. Needs ttl_pkg.
module lexer_token_check import ttl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [3:0]  token_kind_o,
  input  logic [15:0] start_offset_o,
  input  logic [15:0] token_length_o,
  input  logic [31:0] literal_value_o,
  input  logic [31:0] ident_hash_o,
  input  logic [1:0]  error_cause_o,
  input  logic        last_result_o,
  output int          mismatch_count,
  output int          tokens_owed
);

  // Tokens predicted but not yet seen on the result port, oldest first
  tok_t want_tokens[$];

  // Lexer state as predicted
  run_kind_e             cur_run;
  logic [OFFSET_WIDTH-1:0] next_pos;
  logic [OFFSET_WIDTH-1:0] run_begin;
  logic [31:0]           run_val;
  logic [31:0]           run_hsh;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
  endfunction

  // Single-byte punctuation token; TK_ERROR means the byte is not punctuation
  function automatic tok_kind_e punct_of(input logic [7:0] c);
    case (c)
      CH_LPAREN: return TK_LPAREN;
      CH_RPAREN: return TK_RPAREN;
      CH_LBRACE: return TK_LBRACE;
      CH_RBRACE: return TK_RBRACE;
      CH_COMMA:  return TK_COMMA;
      CH_EQUAL:  return TK_EQUAL;
      CH_MINUS:  return TK_MINUS;
      CH_SEMI:   return TK_SEMI;
      default:   return TK_ERROR;
    endcase
  endfunction

  // Saturate a position or length to the result field width
  function automatic logic [FIELD_W-1:0] fit_field(input logic [OFFSET_WIDTH:0] v);
    if (v > 65535) begin
      return '1;
    end
    return FIELD_W'(v);
  endfunction

  function automatic void clear_run();
    cur_run   = RUN_NONE;
    next_pos  = '0;
    run_begin = '0;
    run_val   = '0;
    run_hsh   = '0;
  endfunction

  function automatic void add_token(input tok_kind_e k, input logic [OFFSET_WIDTH:0] first_at,
                                    input logic [OFFSET_WIDTH:0] span, input logic [31:0] v,
                                    input logic [31:0] h, input err_cause_e c);
    tok_t t;
    t.kind  = k;
    t.start = fit_field(first_at);
    t.len   = fit_field(span);
    t.value = v;
    t.hash  = h;
    t.cause = c;
    t.last  = 1'b0;
    want_tokens = {want_tokens, t};
  endfunction

  // Advance the predicted lexer by one byte and queue the tokens it completes
  function automatic void lex_byte(input logic [7:0] c, input logic eob);
    logic                  fresh;
    logic [OFFSET_WIDTH:0] pos_x;
    logic [OFFSET_WIDTH:0] begin_x;
    logic [OFFSET_WIDTH:0] after;
    int                    base_n;
    base_n  = want_tokens.size();
    pos_x   = {1'b0, next_pos};
    begin_x = {1'b0, run_begin};
    fresh   = 1'b1;

    // Continue or close the pending run
    case (cur_run)
      RUN_STRING: begin
        fresh = 1'b0;
        if (c == CH_QUOTE) begin
          add_token(TK_STRING, begin_x, pos_x - begin_x + 1'b1, '0, '0, ERR_NONE);
          cur_run = RUN_NONE;
        end
      end
      RUN_INT: begin
        if (is_dig(c)) begin
          run_val = run_val * DEC_MULT + 32'(c - CH_ZERO);
          fresh   = 1'b0;
        end else begin
          add_token(TK_INT, begin_x, pos_x - begin_x, run_val, '0, ERR_NONE);
          cur_run = RUN_NONE;
        end
      end
      RUN_IDENT: begin
        if (is_alpha(c) || is_dig(c)) begin
          run_hsh = run_hsh * HASH_MULT + 32'(c);
          fresh   = 1'b0;
        end else begin
          add_token(TK_IDENT, begin_x, pos_x - begin_x, '0, run_hsh, ERR_NONE);
          cur_run = RUN_NONE;
        end
      end
      default: ;
    endcase

    // Lex the byte on its own
    if (fresh && !is_blank(c)) begin
      if (punct_of(c) != TK_ERROR) begin
        add_token(punct_of(c), pos_x, SPAN_ONE, '0, '0, ERR_NONE);
      end else if (c == CH_QUOTE) begin
        cur_run   = RUN_STRING;
        run_begin = next_pos;
      end else if (is_dig(c)) begin
        cur_run   = RUN_INT;
        run_begin = next_pos;
        run_val   = 32'(c - CH_ZERO);
      end else if (is_alpha(c)) begin
        cur_run   = RUN_IDENT;
        run_begin = next_pos;
        run_hsh   = 32'(c);
      end else begin
        add_token(TK_ERROR, pos_x, SPAN_ONE, '0, '0, ERR_UNEXPECT);
      end
    end

    // Flush at the end of the buffer, else step the saturating position
    if (eob) begin
      begin_x = {1'b0, run_begin};
      after   = (next_pos < POS_LIMIT) ? pos_x + 1'b1 : pos_x;
      case (cur_run)
        RUN_INT:    add_token(TK_INT, begin_x, after - begin_x, run_val, '0, ERR_NONE);
        RUN_IDENT:  add_token(TK_IDENT, begin_x, after - begin_x, '0, run_hsh, ERR_NONE);
        RUN_STRING: add_token(TK_ERROR, begin_x, pos_x - begin_x + 1'b1, '0, '0, ERR_UNTERM);
        default: ;
      endcase
      add_token(TK_END, pos_x + 1'b1, '0, '0, '0, ERR_NONE);
      clear_run();
    end else if (next_pos < POS_LIMIT) begin
      next_pos = next_pos + 1'b1;
    end

    if (want_tokens.size() > base_n) begin
      want_tokens[want_tokens.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare result beats first, then predict the byte beat of the same edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    tok_t exp_tok;
    if (!rst_ni) begin
      want_tokens.delete();
      clear_run();
      mismatch_count = 0;
      tokens_owed <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (want_tokens.size() == 0) begin
          $display("%0t: unexpected token, expected none, actual kind %0d start %0d",
                   $time, token_kind_o, start_offset_o);
          mismatch_count++;
        end else begin
          exp_tok = want_tokens.pop_front();
          check_field("token_kind", 32'(exp_tok.kind), 32'(token_kind_o));
          check_field("start_offset", 32'(exp_tok.start), 32'(start_offset_o));
          check_field("token_length", 32'(exp_tok.len), 32'(token_length_o));
          check_field("literal_value", exp_tok.value, literal_value_o);
          check_field("ident_hash", exp_tok.hash, ident_hash_o);
          check_field("error_cause", 32'(exp_tok.cause), 32'(error_cause_o));
          check_field("last_result", 32'(exp_tok.last), 32'(last_result_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        lex_byte(data_byte_i, end_of_buffer_i);
      end
      tokens_owed <= want_tokens.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top-level bench for text_token_lexer_unit: clock, reset, byte stimulus,
// result-side back-pressure and the verdict. Needs ttl_pkg and lexer_token_check.
module testbench;
  import ttl_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 125;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        end_of_buffer_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  token_kind_o;
  logic [15:0] start_offset_o;
  logic [15:0] token_length_o;
  logic [31:0] literal_value_o;
  logic [31:0] ident_hash_o;
  logic [1:0]  error_cause_o;
  logic        last_result_o;

  int   mismatch_count;
  int   tokens_owed;
  int   cycle_count = 0;
  int   random_sent = 0;
  logic hold_req = 1'b0;
  logic calm = 1'b0;

  logic [7:0] punct_chars [8] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                                  CH_COMMA, CH_EQUAL, CH_MINUS, CH_SEMI};

  text_token_lexer_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .token_kind_o    (token_kind_o),
    .start_offset_o  (start_offset_o),
    .token_length_o  (token_length_o),
    .literal_value_o (literal_value_o),
    .ident_hash_o    (ident_hash_o),
    .error_cause_o   (error_cause_o),
    .last_result_o   (last_result_o)
  );

  lexer_token_check u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .token_kind_o    (token_kind_o),
    .start_offset_o  (start_offset_o),
    .token_length_o  (token_length_o),
    .literal_value_o (literal_value_o),
    .ident_hash_o    (ident_hash_o),
    .error_cause_o   (error_cause_o),
    .last_result_o   (last_result_o),
    .mismatch_count  (mismatch_count),
    .tokens_owed     (tokens_owed)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL text_token_lexer_unit");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin : result_side
    int   held;
    logic hold_done;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) begin
          @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] alpha_char();
    if ($urandom_range(0, 1) == 0) begin
      return 8'(CH_UP_A + $urandom_range(0, 25));
    end
    return 8'(CH_LO_A + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] blank_char();
    int pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) begin
      return CH_SPACE;
    end
    return 8'(CH_TAB + pick - 1);
  endfunction

  // Offer one byte beat, after an optional gap, and hold it until accepted
  task automatic put_byte(input logic [7:0] b, input logic eob);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_buffer_i <= eob;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic put_text(input string s, input logic eob);
    int i;
    for (i = 0; i < s.len(); i++) begin
      put_byte(s[i], eob && i == s.len() - 1);
    end
  endtask

  // Drop valid and wait until every predicted token has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tokens_owed != 0);
  endtask

  // One lexically shaped fragment with random content; sometimes ends the buffer
  task automatic random_fragment();
    logic [7:0] frag[$];
    logic [7:0] b;
    logic       eob_here;
    int         len;
    int         pick;
    int         i;
    pick     = $urandom_range(0, 15);
    eob_here = $urandom_range(0, 11) == 0;
    if (pick < 4) begin
      // identifier
      len = $urandom_range(0, 7);
      frag = {frag, alpha_char()};
      for (i = 0; i < len; i++) begin
        frag = {frag, ($urandom_range(0, 3) == 0 ? digit_char() : alpha_char())};
      end
    end else if (pick < 7) begin
      // integer, long enough at times to wrap
      len = $urandom_range(1, 12);
      for (i = 0; i < len; i++) begin
        frag = {frag, digit_char()};
      end
    end else if (pick < 9) begin
      // string, sometimes left open
      frag = {frag, CH_QUOTE};
      len = $urandom_range(0, 6);
      for (i = 0; i < len; i++) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
        frag = {frag, b};
      end
      if ($urandom_range(0, 5) != 0) begin
        frag = {frag, CH_QUOTE};
      end
    end else if (pick < 12) begin
      frag = {frag, punct_chars[$urandom_range(0, 7)]};
    end else if (pick < 14) begin
      len = $urandom_range(1, 3);
      for (i = 0; i < len; i++) begin
        frag = {frag, blank_char()};
      end
    end else begin
      // raw noise byte
      frag = {frag, 8'($urandom_range(0, 255))};
    end
    for (i = 0; i < frag.size(); i++) begin
      put_byte(frag[i], eob_here && i == frag.size() - 1);
    end
    random_sent += frag.size();
  endtask

  initial begin : byte_side
    int   k;
    logic paused;
    paused          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = 8'h00;
    end_of_buffer_i = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all punctuation, all blanks, run endings, strings, bad bytes
    put_text("(){},=-;", 1'b0);
    put_byte(CH_SPACE, 1'b0);
    for (k = 0; k < 5; k++) begin
      put_byte(8'(CH_TAB + k), 1'b0);
    end
    put_text("x9;", 1'b1);
    put_text("\"a", 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(CH_QUOTE, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h80, 1'b0);
    put_text("12Z", 1'b1);
    put_text("\"q", 1'b1);
    put_text("7", 1'b0);
    put_byte(8'h7F, 1'b1);
    put_text("abcdefgh12(99\"xy", 1'b1);

    // Random fragments, with a long result hold-off and one full drain
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent >= 30) begin
        hold_req = 1'b1;
      end
      if (random_sent >= 75 && !paused) begin
        paused = 1'b1;
        wait_drained();
      end
      if (random_sent >= 100) begin
        calm = 1'b1;
      end
      random_fragment();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS text_token_lexer_unit");
    end else begin
      $display("FAIL text_token_lexer_unit");
    end
    $finish;
  end

endmodule
